/* hw/rtl/evcsc_pkg.sv */
package evcsc_pkg;

    localparam int KIND_W   = 3;
    localparam int MODE_W   = 3;
    localparam int AMPS_W   = 7;
    localparam int VOLT_W   = 9;
    localparam int POWER_W  = 16;
    localparam int TIME_W   = 32;
    localparam int IVAL_W   = 16;
    localparam int ENERGY_W = 48;
    localparam int DUTY_W   = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MANUAL  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REMOTE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STOP    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ENABLE  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DISABLE = 3'd5;

    localparam logic [MODE_W-1:0] MODE_DISABLED = 3'd0;
    localparam logic [MODE_W-1:0] MODE_IDLE     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WAIT     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CHARGING = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FAULT    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_VOLTAGE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_CURRENT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_VOLTAGE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_METER_INTERVAL = 3'd4;

    localparam logic [AMPS_W-1:0] DUTY_PCT_MIN = 7'd10;
    localparam logic [AMPS_W-1:0] DUTY_PCT_MAX = 7'd80;

    // Division by 100 is a multiply by a rounded-up reciprocal and a shift.
    localparam int DIV100_SHIFT = 30;
    localparam int DIV100_W     = 24;
    localparam logic [DIV100_W-1:0] DIV100_MUL = DIV100_W'(((64'd1 << DIV100_SHIFT) + 64'd99) / 64'd100);

    typedef struct packed {
        logic capture;
        logic eval;
        logic mul1;
        logic mul2;
        logic acc;
        logic load;
    } evcsc_cmd_t;

    typedef struct packed {
        logic out_blocked;
    } evcsc_status_t;

endpackage

/* hw/rtl/ev_charge_session_controller_unit.sv */
// Each transaction is accepted while the sequencer is idle and then steps through the eval, mul1,
// mul2, acc and done states; a new one is accepted only after its result is loaded at done.
// The sequencer steps serially through the power and energy multipliers and the
// saturating 48-bit energy adder; a stalled result holds the next one at its final step.
// Reset is asynchronous and active low: mode idle, registers at their reset values, no result.
module ev_charge_session_controller_unit
    import evcsc_pkg::*;
#(
    parameter int DUTY_BITS = 10,
    parameter int MIN_AMPS  = 6,
    parameter int MAX_AMPS  = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [KIND_W-1:0]     kind,
    input  logic [TIME_W-1:0]     now_ms,
    input  logic                  safety_ok,
    input  logic                  car_present,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [MODE_W-1:0]     charger_state,
    output logic                  contactor_closed,
    output logic [DUTY_W-1:0]     pilot_duty,
    output logic [VOLT_W-1:0]     sample_voltage,
    output logic [AMPS_W-1:0]     sample_current,
    output logic [POWER_W-1:0]    sample_power,
    output logic [ENERGY_W-1:0]   session_energy,
    output logic                  sample_taken
);

    evcsc_cmd_t    cmd;
    evcsc_status_t status;
    logic          busy;

    evcsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy)
    );

    evcsc_datapath #(
        .DUTY_BITS (DUTY_BITS),
        .MIN_AMPS  (MIN_AMPS),
        .MAX_AMPS  (MAX_AMPS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .kind             (kind),
        .now_ms           (now_ms),
        .safety_ok        (safety_ok),
        .car_present      (car_present),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .charger_state    (charger_state),
        .contactor_closed (contactor_closed),
        .pilot_duty       (pilot_duty),
        .sample_voltage   (sample_voltage),
        .sample_current   (sample_current),
        .sample_power     (sample_power),
        .session_energy   (session_energy),
        .sample_taken     (sample_taken)
    );

    assign in_stall = busy;

    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("transaction accepted without the sequencer starting");

    a_contactor_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (contactor_closed == (charger_state == MODE_CHARGING)))
        else $error("contactor does not follow the charging mode");

    a_disabled_duty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (charger_state == MODE_DISABLED)) |-> (pilot_duty == '0))
        else $error("pilot duty nonzero while disabled");

    a_no_result_while_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !out_valid) |=> !out_valid)
        else $error("result appeared one cycle after acceptance");

endmodule

/* hw/rtl/evcsc_ctrl.sv */
module evcsc_ctrl
    import evcsc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  evcsc_status_t status,
    output evcsc_cmd_t    cmd,
    output logic          busy
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_EVAL = 6'b000010,
        ST_MUL1 = 6'b000100,
        ST_MUL2 = 6'b001000,
        ST_ACC  = 6'b010000,
        ST_DONE = 6'b100000
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!status.out_blocked)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

/* hw/rtl/evcsc_datapath.sv */
module evcsc_datapath
    import evcsc_pkg::*;
#(
    parameter int DUTY_BITS = 10,
    parameter int MIN_AMPS  = 6,
    parameter int MAX_AMPS  = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  evcsc_cmd_t            cmd,
    output evcsc_status_t         status,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [KIND_W-1:0]     kind,
    input  logic [TIME_W-1:0]     now_ms,
    input  logic                  safety_ok,
    input  logic                  car_present,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [MODE_W-1:0]     charger_state,
    output logic                  contactor_closed,
    output logic [DUTY_W-1:0]     pilot_duty,
    output logic [VOLT_W-1:0]     sample_voltage,
    output logic [AMPS_W-1:0]     sample_current,
    output logic [POWER_W-1:0]    sample_power,
    output logic [ENERGY_W-1:0]   session_energy,
    output logic                  sample_taken
);

    localparam int PW = DUTY_BITS + AMPS_W;
    localparam int QW = PW + DIV100_W;
    localparam logic [DUTY_BITS-1:0] DUTY_FULL = '1;

    logic [AMPS_W-1:0]   cfg_limit_reg;
    logic [VOLT_W-1:0]   cfg_cv_reg;
    logic [AMPS_W-1:0]   cfg_cc_reg;
    logic [VOLT_W-1:0]   cfg_gv_reg;
    logic [IVAL_W-1:0]   cfg_ival_reg;

    logic [KIND_W-1:0]   kind_reg;
    logic [TIME_W-1:0]   now_reg;
    logic                safe_reg;
    logic                car_reg;

    logic [MODE_W-1:0]   mode_reg;
    logic [MODE_W-1:0]   mode_next;
    logic                start_pend_reg;
    logic                start_pend_next;
    logic                stop_pend_reg;
    logic                stop_pend_next;
    logic                begin_next;
    logic                sample_next;
    logic                sample_reg;
    logic [TIME_W-1:0]   last_meter_reg;
    logic [TIME_W-1:0]   last_energy_reg;
    logic [ENERGY_W-1:0] energy_reg;
    logic [VOLT_W-1:0]   held_v_reg;
    logic [AMPS_W-1:0]   held_i_reg;
    logic [POWER_W-1:0]  held_p_reg;

    logic [AMPS_W-1:0]   amps_clamp;
    logic [AMPS_W-1:0]   amps_pct;
    logic [AMPS_W-1:0]   amps_reg;
    logic [TIME_W-1:0]   dt_reg;
    logic [ENERGY_W-1:0] add_next;
    logic [ENERGY_W-1:0] add_reg;
    logic [ENERGY_W:0]   energy_sum;
    logic [PW-1:0]       duty_p_reg;
    logic [QW-1:0]       duty_prod;
    logic [PW-1:0]       duty_q_reg;
    logic                can_start;
    logic [VOLT_W-1:0]   v_sel;
    logic [AMPS_W-1:0]   i_sel;

    logic                out_valid_reg;
    logic [MODE_W-1:0]   out_state_reg;
    logic [DUTY_W-1:0]   out_duty_reg;
    logic [VOLT_W-1:0]   out_v_reg;
    logic [AMPS_W-1:0]   out_i_reg;
    logic [POWER_W-1:0]  out_p_reg;
    logic [ENERGY_W-1:0] out_e_reg;
    logic                out_sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_limit_reg <= 7'd16;
            cfg_cv_reg    <= 9'd5;
            cfg_cc_reg    <= 7'd1;
            cfg_gv_reg    <= 9'd230;
            cfg_ival_reg  <= 16'd1000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CURRENT_LIMIT:  cfg_limit_reg <= cfg_data[AMPS_W-1:0];
                CFG_CHARGE_VOLTAGE: cfg_cv_reg    <= cfg_data[VOLT_W-1:0];
                CFG_CHARGE_CURRENT: cfg_cc_reg    <= cfg_data[AMPS_W-1:0];
                CFG_GRID_VOLTAGE:   cfg_gv_reg    <= cfg_data[VOLT_W-1:0];
                CFG_METER_INTERVAL: cfg_ival_reg  <= cfg_data[IVAL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind;
            now_reg  <= now_ms;
            safe_reg <= safety_ok;
            car_reg  <= car_present;
        end
    end

    assign can_start = (mode_reg == MODE_IDLE) || (mode_reg == MODE_WAIT);

    always_comb
    begin
        mode_next       = mode_reg;
        start_pend_next = start_pend_reg;
        stop_pend_next  = stop_pend_reg;
        begin_next      = 1'b0;
        case (kind_reg)
            KIND_TICK:
            begin
                case (mode_reg)
                    MODE_IDLE:
                    begin
                        if (!safe_reg)
                        begin
                            mode_next = MODE_FAULT;
                        end
                        else if (start_pend_reg)
                        begin
                            start_pend_next = 1'b0;
                            mode_next       = MODE_WAIT;
                        end
                    end
                    MODE_WAIT:
                    begin
                        if (!safe_reg)
                        begin
                            mode_next = MODE_FAULT;
                        end
                        else if (!car_reg)
                        begin
                            mode_next = MODE_IDLE;
                        end
                        else if (start_pend_reg)
                        begin
                            begin_next = 1'b1;
                        end
                    end
                    MODE_CHARGING:
                    begin
                        if (!safe_reg || !car_reg || stop_pend_reg)
                        begin
                            mode_next       = safe_reg ? MODE_IDLE : MODE_FAULT;
                            start_pend_next = 1'b0;
                            stop_pend_next  = 1'b0;
                        end
                    end
                    MODE_FAULT:
                    begin
                        if (safe_reg && !car_reg)
                        begin
                            mode_next = MODE_IDLE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            KIND_MANUAL:
            begin
                if (can_start)
                begin
                    start_pend_next = 1'b1;
                end
            end
            KIND_REMOTE:
            begin
                if (can_start && safe_reg && car_reg)
                begin
                    begin_next = 1'b1;
                end
            end
            KIND_STOP:
            begin
                stop_pend_next = 1'b1;
            end
            KIND_ENABLE, KIND_DISABLE:
            begin
                mode_next       = (kind_reg == KIND_ENABLE) ? MODE_IDLE : MODE_DISABLED;
                start_pend_next = 1'b0;
                stop_pend_next  = 1'b0;
            end
            default:
            begin
            end
        endcase
        if (begin_next)
        begin
            mode_next       = MODE_CHARGING;
            start_pend_next = 1'b0;
        end
    end

    assign sample_next = (kind_reg == KIND_TICK) &&
                         ((now_reg - last_meter_reg) >= {{(TIME_W-IVAL_W){1'b0}}, cfg_ival_reg});

    always_comb
    begin
        if (cfg_limit_reg < AMPS_W'(MIN_AMPS))
        begin
            amps_clamp = AMPS_W'(MIN_AMPS);
        end
        else if (cfg_limit_reg > AMPS_W'(MAX_AMPS))
        begin
            amps_clamp = AMPS_W'(MAX_AMPS);
        end
        else
        begin
            amps_clamp = cfg_limit_reg;
        end
        if (amps_clamp < DUTY_PCT_MIN)
        begin
            amps_pct = DUTY_PCT_MIN;
        end
        else if (amps_clamp > DUTY_PCT_MAX)
        begin
            amps_pct = DUTY_PCT_MAX;
        end
        else
        begin
            amps_pct = amps_clamp;
        end
    end

    assign v_sel      = (mode_reg == MODE_CHARGING) ? cfg_cv_reg : cfg_gv_reg;
    assign i_sel      = (mode_reg == MODE_CHARGING) ? cfg_cc_reg : '0;
    assign add_next   = ENERGY_W'(held_p_reg) * ENERGY_W'(dt_reg);
    assign duty_prod  = QW'(duty_p_reg) * QW'(DIV100_MUL);
    assign energy_sum = {1'b0, energy_reg} + {1'b0, add_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_IDLE;
            start_pend_reg  <= 1'b0;
            stop_pend_reg   <= 1'b0;
            sample_reg      <= 1'b0;
            last_meter_reg  <= '0;
            last_energy_reg <= '0;
            energy_reg      <= '0;
            held_v_reg      <= '0;
            held_i_reg      <= '0;
            held_p_reg      <= '0;
        end
        else
        begin
            if (cmd.eval)
            begin
                mode_reg       <= mode_next;
                start_pend_reg <= start_pend_next;
                stop_pend_reg  <= stop_pend_next;
                sample_reg     <= sample_next;
                if (sample_next)
                begin
                    last_meter_reg <= now_reg;
                end
                if (begin_next)
                begin
                    energy_reg      <= '0;
                    last_energy_reg <= now_reg;
                end
            end
            if (cmd.mul1 && sample_reg)
            begin
                held_v_reg      <= v_sel;
                held_i_reg      <= i_sel;
                held_p_reg      <= POWER_W'(v_sel) * POWER_W'(i_sel);
                last_energy_reg <= now_reg;
            end
            if (cmd.acc && sample_reg)
            begin
                energy_reg <= energy_sum[ENERGY_W] ? '1 : energy_sum[ENERGY_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            amps_reg <= amps_pct;
        end
        if (cmd.mul1)
        begin
            dt_reg     <= now_reg - last_energy_reg;
            duty_p_reg <= PW'(DUTY_FULL) * PW'(amps_reg);
        end
        if (cmd.mul2)
        begin
            add_reg    <= add_next;
            duty_q_reg <= PW'(duty_prod >> DIV100_SHIFT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_state_reg  <= mode_reg;
            out_duty_reg   <= (mode_reg == MODE_DISABLED) ? '0 : duty_q_reg[DUTY_W-1:0];
            out_v_reg      <= held_v_reg;
            out_i_reg      <= held_i_reg;
            out_p_reg      <= held_p_reg;
            out_e_reg      <= energy_reg;
            out_sample_reg <= sample_reg;
        end
    end

    assign status.out_blocked = out_valid_reg && out_stall;

    assign out_valid        = out_valid_reg;
    assign charger_state    = out_state_reg;
    assign contactor_closed = (out_state_reg == MODE_CHARGING);
    assign pilot_duty       = out_duty_reg;
    assign sample_voltage   = out_v_reg;
    assign sample_current   = out_i_reg;
    assign sample_power     = out_p_reg;
    assign session_energy   = out_e_reg;
    assign sample_taken     = out_sample_reg;

endmodule

/* dv/tb.sv */
module tb;
    import evcsc_pkg::*;

    localparam int DUTY_BITS = 10;
    localparam int MIN_AMPS  = 6;
    localparam int MAX_AMPS  = 32;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 10;

    localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;
    localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

    typedef struct packed {
        logic [MODE_W-1:0]   state;
        logic                contactor;
        logic [DUTY_W-1:0]   duty;
        logic [VOLT_W-1:0]   volts;
        logic [AMPS_W-1:0]   amps;
        logic [POWER_W-1:0]  watts;
        logic [ENERGY_W-1:0] energy;
        logic                sampled;
    } charger_report_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [KIND_W-1:0]     kind = '0;
    logic [TIME_W-1:0]     now_ms = '0;
    logic                  safety_ok = 1'b0;
    logic                  car_present = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [MODE_W-1:0]     charger_state;
    logic                  contactor_closed;
    logic [DUTY_W-1:0]     pilot_duty;
    logic [VOLT_W-1:0]     sample_voltage;
    logic [AMPS_W-1:0]     sample_current;
    logic [POWER_W-1:0]    sample_power;
    logic [ENERGY_W-1:0]   session_energy;
    logic                  sample_taken;

    // Registers as the block should hold them.
    logic [AMPS_W-1:0]  cfg_limit = 7'd16;
    logic [VOLT_W-1:0]  cfg_chg_volts = 9'd5;
    logic [AMPS_W-1:0]  cfg_chg_amps = 7'd1;
    logic [VOLT_W-1:0]  cfg_grid_volts = 9'd230;
    logic [IVAL_W-1:0]  cfg_interval = 16'd1000;

    // Session state as the block should hold it.
    logic [MODE_W-1:0]   sess_mode = MODE_IDLE;
    logic                start_req = 1'b0;
    logic                stop_req = 1'b0;
    logic [TIME_W-1:0]   meter_stamp = '0;
    logic [TIME_W-1:0]   energy_stamp = '0;
    logic [ENERGY_W-1:0] energy_wms = '0;
    logic [VOLT_W-1:0]   held_volts = '0;
    logic [AMPS_W-1:0]   held_amps = '0;
    logic [POWER_W-1:0]  held_watts = '0;

    charger_report_t pending_reports[$];

    logic [TIME_W-1:0] wall_ms = '0;
    int unsigned items_sent = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_request = 0;
    int unsigned hold_left = 0;

    ev_charge_session_controller_unit #(
        .DUTY_BITS(DUTY_BITS),
        .MIN_AMPS(MIN_AMPS),
        .MAX_AMPS(MAX_AMPS)
    ) dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // The receiver stalls at random, or holds off for a requested number of cycles.
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            check_report();
        end
    end

    function automatic logic mostly(input int unsigned pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic logic [TIME_W-1:0] tick_gap();
        return $urandom_range(2 * cfg_interval + 1, 0);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_setting(input int unsigned top);
        case ($urandom_range(3))
            0: return '0;
            1: return CFG_DATA_W'(top);
            2: return CFG_DATA_W'($urandom_range(top, 0));
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            error_count++;
        end
    endtask

    task automatic check_report();
        charger_report_t want;
        if (pending_reports.size() == 0)
        begin
            $error("result with no transaction waiting for it");
            error_count++;
            return;
        end
        want = pending_reports.pop_front();
        compare_field("charger_state", 64'(want.state), 64'(charger_state));
        compare_field("contactor_closed", 64'(want.contactor), 64'(contactor_closed));
        compare_field("pilot_duty", 64'(want.duty), 64'(pilot_duty));
        compare_field("sample_voltage", 64'(want.volts), 64'(sample_voltage));
        compare_field("sample_current", 64'(want.amps), 64'(sample_current));
        compare_field("sample_power", 64'(want.watts), 64'(sample_power));
        compare_field("session_energy", 64'(want.energy), 64'(session_energy));
        compare_field("sample_taken", 64'(want.sampled), 64'(sample_taken));
    endtask

    task automatic begin_session(input logic [TIME_W-1:0] t);
        energy_wms = '0;
        energy_stamp = t;
        sess_mode = MODE_CHARGING;
        start_req = 1'b0;
    endtask

    // Applies one event to the session state and queues the report it should produce.
    task automatic advance_session(input logic [KIND_W-1:0] k, input logic [TIME_W-1:0] t,
                                   input logic safe, input logic car);
        charger_report_t r;
        logic sampled;
        logic can_start;
        logic [TIME_W-1:0] dt;
        logic [ENERGY_W:0] sum;
        int unsigned amps;
        longint unsigned full;
        sampled = 1'b0;
        can_start = (sess_mode == MODE_IDLE) || (sess_mode == MODE_WAIT);
        case (k)
            KIND_TICK:
            begin
                case (sess_mode)
                    MODE_IDLE:
                        if (!safe)
                            sess_mode = MODE_FAULT;
                        else if (start_req)
                        begin
                            start_req = 1'b0;
                            sess_mode = MODE_WAIT;
                        end
                    MODE_WAIT:
                        if (!safe)
                            sess_mode = MODE_FAULT;
                        else if (!car)
                            sess_mode = MODE_IDLE;
                        else if (start_req)
                            begin_session(t);
                    MODE_CHARGING:
                        if (!safe || !car || stop_req)
                        begin
                            sess_mode = safe ? MODE_IDLE : MODE_FAULT;
                            start_req = 1'b0;
                            stop_req = 1'b0;
                        end
                    MODE_FAULT:
                        if (safe && !car)
                            sess_mode = MODE_IDLE;
                    default: ;
                endcase
                if (t - meter_stamp >= TIME_W'(cfg_interval))
                begin
                    meter_stamp = t;
                    sampled = 1'b1;
                    if (sess_mode == MODE_CHARGING)
                    begin
                        held_volts = cfg_chg_volts;
                        held_amps = cfg_chg_amps;
                    end
                    else
                    begin
                        held_volts = cfg_grid_volts;
                        held_amps = '0;
                    end
                    held_watts = POWER_W'(held_volts) * POWER_W'(held_amps);
                    dt = t - energy_stamp;
                    energy_stamp = t;
                    if (dt != '0 && held_watts != '0)
                    begin
                        sum = {1'b0, energy_wms}
                              + (ENERGY_W + 1)'(held_watts) * (ENERGY_W + 1)'(dt);
                        energy_wms = sum[ENERGY_W] ? ENERGY_MAX : sum[ENERGY_W-1:0];
                    end
                end
            end
            KIND_MANUAL:
                if (can_start)
                    start_req = 1'b1;
            KIND_REMOTE:
                if (can_start && safe && car)
                    begin_session(t);
            KIND_STOP:
                stop_req = 1'b1;
            KIND_ENABLE, KIND_DISABLE:
            begin
                sess_mode = (k == KIND_ENABLE) ? MODE_IDLE : MODE_DISABLED;
                start_req = 1'b0;
                stop_req = 1'b0;
            end
            default: ;
        endcase

        amps = 32'(cfg_limit);
        full = (64'd1 << DUTY_BITS) - 64'd1;
        if (amps < MIN_AMPS)
            amps = MIN_AMPS;
        else if (amps > MAX_AMPS)
            amps = MAX_AMPS;
        if (amps < 32'(DUTY_PCT_MIN))
            amps = 32'(DUTY_PCT_MIN);
        else if (amps > 32'(DUTY_PCT_MAX))
            amps = 32'(DUTY_PCT_MAX);

        r.state = sess_mode;
        r.contactor = (sess_mode == MODE_CHARGING);
        r.duty = (sess_mode == MODE_DISABLED) ? '0 : DUTY_W'((full * 64'(amps)) / 64'd100);
        r.volts = held_volts;
        r.amps = held_amps;
        r.watts = held_watts;
        r.energy = energy_wms;
        r.sampled = sampled;
        pending_reports.push_back(r);
    endtask

    // Offers one event, step milliseconds after the previous one, and waits until it is taken.
    task automatic send_event(input logic [KIND_W-1:0] k, input logic [TIME_W-1:0] step,
                              input logic safe, input logic car);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        wall_ms = wall_ms + step;
        in_valid <= 1'b1;
        kind <= k;
        now_ms <= wall_ms;
        safety_ok <= safe;
        car_present <= car;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        advance_session(k, wall_ms, safe, car);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CURRENT_LIMIT:  cfg_limit = value[AMPS_W-1:0];
            CFG_CHARGE_VOLTAGE: cfg_chg_volts = value[VOLT_W-1:0];
            CFG_CHARGE_CURRENT: cfg_chg_amps = value[AMPS_W-1:0];
            CFG_GRID_VOLTAGE:   cfg_grid_volts = value[VOLT_W-1:0];
            CFG_METER_INTERVAL: cfg_interval = value[IVAL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic charge_and_stop();
        repeat ($urandom_range(8, 1))
            send_event(KIND_TICK, tick_gap(), mostly(97), mostly(95));
        if (mostly(70))
            send_event(KIND_STOP, tick_gap(), mostly(95), mostly(95));
        send_event(KIND_TICK, tick_gap(), mostly(97), mostly(95));
    endtask

    // Mostly complete sessions with random timing and flags, with some noise in between.
    task automatic run_random_sessions(input int unsigned count);
        int unsigned target;
        target = items_sent + count;
        while (items_sent < target)
        begin
            case ($urandom_range(5))
                0, 1:
                begin
                    if (mostly(60))
                        send_event(KIND_ENABLE, tick_gap(), mostly(95), mostly(95));
                    send_event(KIND_MANUAL, tick_gap(), mostly(95), mostly(95));
                    send_event(KIND_TICK, tick_gap(), mostly(95), mostly(90));
                    send_event(KIND_MANUAL, tick_gap(), mostly(95), mostly(95));
                    send_event(KIND_TICK, tick_gap(), mostly(95), mostly(90));
                    charge_and_stop();
                end
                2, 3:
                begin
                    if (mostly(60))
                        send_event(KIND_ENABLE, tick_gap(), mostly(95), mostly(95));
                    send_event(KIND_REMOTE, tick_gap(), mostly(90), mostly(90));
                    charge_and_stop();
                end
                4:
                begin
                    send_event(KIND_TICK, tick_gap(), 1'b0, 1'($urandom_range(1)));
                    repeat ($urandom_range(3))
                        send_event(KIND_TICK, tick_gap(), 1'($urandom_range(1)),
                                   1'($urandom_range(1)));
                    send_event(KIND_TICK, tick_gap(), 1'b1, 1'b0);
                end
                default:
                begin
                    repeat ($urandom_range(3, 1))
                        send_event(KIND_W'($urandom_range(7)),
                                   mostly(10) ? TIME_W'($urandom) : tick_gap(),
                                   1'($urandom_range(1)), 1'($urandom_range(1)));
                end
            endcase
        end
    endtask

    task automatic test_directed_events();
        send_event(KIND_TICK, 32'd1000, 1'b1, 1'b1);
        send_event(KIND_UNUSED_LO, 32'hFFFF_FC17, 1'b0, 1'b0);
        send_event(KIND_UNUSED_HI, 32'd0, 1'b1, 1'b1);
        send_event(KIND_TICK, 32'd1, 1'b1, 1'b1);
        send_event(KIND_MANUAL, 32'd10, 1'b1, 1'b1);
        send_event(KIND_TICK, 32'd10, 1'b1, 1'b1);
        send_event(KIND_TICK, 32'd10, 1'b1, 1'b0);
        send_event(KIND_MANUAL, 32'd10, 1'b1, 1'b1);
        send_event(KIND_TICK, 32'd10, 1'b1, 1'b1);
        send_event(KIND_MANUAL, 32'd10, 1'b1, 1'b1);
        send_event(KIND_TICK, 32'd1500, 1'b1, 1'b1);
        send_event(KIND_TICK, 32'd1500, 1'b1, 1'b1);
        send_event(KIND_STOP, 32'd5, 1'b1, 1'b1);
        send_event(KIND_MANUAL, 32'd5, 1'b1, 1'b1);
        send_event(KIND_TICK, 32'd5, 1'b1, 1'b1);
        send_event(KIND_REMOTE, 32'd5, 1'b1, 1'b0);
        send_event(KIND_REMOTE, 32'd5, 1'b0, 1'b1);
        send_event(KIND_REMOTE, 32'd5, 1'b1, 1'b1);
        send_event(KIND_TICK, 32'd5, 1'b0, 1'b1);
        send_event(KIND_REMOTE, 32'd5, 1'b1, 1'b1);
        send_event(KIND_TICK, 32'd5, 1'b1, 1'b0);
        send_event(KIND_STOP, 32'd5, 1'b1, 1'b1);
        send_event(KIND_DISABLE, 32'd5, 1'b1, 1'b1);
        send_event(KIND_TICK, 32'd2000, 1'b1, 1'b1);
        send_event(KIND_ENABLE, 32'd5, 1'b1, 1'b1);
        wait_drained();
    endtask

    task automatic test_register_settings();
        for (int i = CFG_METER_INTERVAL + 1; i < 2 ** CFG_IDX_W; i++)
            write_register(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
        write_register(CFG_CURRENT_LIMIT, '0);
        write_register(CFG_GRID_VOLTAGE, 16'hFFFF);
        write_register(CFG_METER_INTERVAL, '0);
        send_event(KIND_TICK, 32'd0, 1'b1, 1'b1);
        send_event(KIND_TICK, 32'd0, 1'b1, 1'b1);
        wait_drained();
        write_register(CFG_CURRENT_LIMIT, 16'hFFFF);
        write_register(CFG_METER_INTERVAL, 16'hFFFF);
        send_event(KIND_TICK, 32'd65534, 1'b1, 1'b1);
        send_event(KIND_TICK, 32'd1, 1'b1, 1'b1);
        wait_drained();
        write_register(CFG_CURRENT_LIMIT, 16'd9);
        write_register(CFG_GRID_VOLTAGE, '0);
        write_register(CFG_METER_INTERVAL, 16'd1);
        send_event(KIND_TICK, 32'd3, 1'b1, 1'b1);
        wait_drained();
    endtask

    // Full-scale power over nearly the whole timestamp range drives the energy into saturation.
    task automatic test_energy_saturation();
        write_register(CFG_CURRENT_LIMIT, 16'd80);
        write_register(CFG_CHARGE_VOLTAGE, 16'hFFFF);
        write_register(CFG_CHARGE_CURRENT, 16'hFFFF);
        send_event(KIND_ENABLE, 32'd1, 1'b1, 1'b1);
        send_event(KIND_REMOTE, 32'd1, 1'b1, 1'b1);
        repeat (3) send_event(KIND_TICK, 32'hFFFF_FFF0, 1'b1, 1'b1);
        send_event(KIND_STOP, 32'd1, 1'b1, 1'b1);
        send_event(KIND_TICK, 32'd1, 1'b1, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int unsigned idle_plan[4];
        int unsigned stall_plan[4];
        idle_plan = '{0, 68, 0, 30};
        stall_plan = '{0, 0, 68, 30};
        for (int p = 0; p < 4; p++)
        begin
            write_register(CFG_CURRENT_LIMIT, pick_setting(80));
            write_register(CFG_CHARGE_VOLTAGE, pick_setting(500));
            write_register(CFG_CHARGE_CURRENT, pick_setting(80));
            write_register(CFG_GRID_VOLTAGE, pick_setting(500));
            write_register(CFG_METER_INTERVAL, pick_setting(65535));
            idle_pct = idle_plan[p];
            stall_pct = stall_plan[p];
            run_random_sessions(220);
            wait_drained();
        end
    endtask

    task automatic test_output_hold_off();
        write_register(CFG_METER_INTERVAL, 16'd1000);
        idle_pct = 0;
        stall_pct = 0;
        hold_request = 300;
        run_random_sessions(60);
        wait_drained();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_events();
        test_register_settings();
        test_energy_saturation();
        test_random_traffic();
        test_output_hold_off();
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
